[design/cxc_pkg.sv]
// Package with the types, constants and coefficient tables of the colour space converter.
`default_nettype none

package cxc_pkg;

    localparam int COMP_W    = 20;
    localparam int FRAC_BITS = 16;
    localparam int COEF_W    = FRAC_BITS + 3;
    localparam int OMXY_W    = ((FRAC_BITS > COMP_W) ? FRAC_BITS : COMP_W) + 3;
    localparam int PROD_W    = COMP_W + OMXY_W;
    localparam int DEN_W     = COMP_W + 2;
    localparam int QB        = COMP_W;
    localparam int DW        = PROD_W + 2;
    localparam int DIV_LAT   = QB + 2;
    localparam int MUL_W     = COMP_W + COEF_W;
    localparam int ACC_W     = MUL_W + 2;

    localparam longint COMP_MAX   = (64'sd1 <<< (COMP_W - 1)) - 1;
    localparam longint COMP_MIN   = -(64'sd1 <<< (COMP_W - 1));
    localparam longint ONE        = 64'sd1 <<< FRAC_BITS;
    localparam longint HALF       = 64'sd1 <<< (FRAC_BITS - 1);
    localparam longint COEF_SCALE = 10000000;
    localparam longint COEF_HALF  = 5000000;

    localparam logic [1:0] FN_XYZ2RGB = 2'd0;
    localparam logic [1:0] FN_RGB2XYZ = 2'd1;
    localparam logic [1:0] FN_XYZ2XYY = 2'd2;
    localparam logic [1:0] FN_XYY2RGB = 2'd3;

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic [1:0] func;
        t_comp      comp_a;
        t_comp      comp_b;
        t_comp      comp_c;
    } t_cmd;

    typedef struct packed {
        t_comp out_a;
        t_comp out_b;
        t_comp out_c;
        logic  zero_divisor;
        logic  clipped;
    } t_res;

    typedef struct packed {
        t_comp a;
        t_comp b;
        t_comp c;
    } t_vec;

    typedef struct packed {
        t_coef k0;
        t_coef k1;
        t_coef k2;
    } t_coef_row;

    typedef struct packed {
        logic [1:0] func;
        logic       zdiv;
        t_vec       v;
    } t_side;

    // Decimal coefficient scaled by 1e7, rounded to FRAC_BITS with ties away from zero.
    function automatic longint coef_of(input longint k);
        return (k * ONE + ((k < 0) ? -COEF_HALF : COEF_HALF)) / COEF_SCALE;
    endfunction

    localparam t_coef XYZ2RGB_K [9] = '{
        t_coef'(coef_of(32404790)), t_coef'(coef_of(-15371500)), t_coef'(coef_of(-4985350)),
        t_coef'(coef_of(-9692560)), t_coef'(coef_of(18759910)),  t_coef'(coef_of(415560)),
        t_coef'(coef_of(556480)),   t_coef'(coef_of(-2040430)),  t_coef'(coef_of(10573110))
    };

    localparam t_coef RGB2XYZ_K [9] = '{
        t_coef'(coef_of(4124530)), t_coef'(coef_of(3575800)), t_coef'(coef_of(1804230)),
        t_coef'(coef_of(2126710)), t_coef'(coef_of(7151600)), t_coef'(coef_of(721688)),
        t_coef'(coef_of(193338)),  t_coef'(coef_of(1191940)), t_coef'(coef_of(9502270))
    };

endpackage

`default_nettype wire

[design/cxc_div.sv]
// Pipelined signed divider lane, one quotient bit per stage, rounded and saturated.
`default_nettype none

module cxc_div
    import cxc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic signed [PROD_W-1:0] i_num,
    input  wire logic signed [DEN_W-1:0]  i_den,
    output t_comp                         o_quo,
    output logic                          o_clip
);

    logic [DW-1:0] r_rem [QB+1];
    logic [DW-1:0] r_den [QB+1];
    logic [QB-1:0] r_quo [QB+1];
    logic          r_neg [QB+1];
    logic          r_ovf [QB+1];

    logic [PROD_W-1:0] n_un;
    logic [DEN_W-1:0]  n_ud;
    logic [DW-1:0]     n_num;
    logic [DW-1:0]     n_dd;

    // Rounding is folded into the operands: q = (2|n| + |d|) / (2|d|).
    always_comb begin
        n_un  = i_num[PROD_W-1] ? PROD_W'(-i_num) : PROD_W'(i_num);
        n_ud  = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
        n_num = (DW'(n_un) << 1) + DW'(n_ud);
        n_dd  = DW'(n_ud) << 1;
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_num;
        r_den[0] <= n_dd;
        r_quo[0] <= '0;
        r_neg[0] <= i_num[PROD_W-1] ^ i_den[DEN_W-1];
        r_ovf[0] <= n_num >= (n_dd << QB);
    end

    for (genvar g = 0; g < QB; g++) begin : g_bit
        localparam int B = QB - 1 - g;
        logic [DW-1:0] n_sub;
        logic          n_ge;
        assign n_sub = r_den[g] << B;
        assign n_ge  = r_rem[g] >= n_sub;
        always_ff @(posedge i_clk) begin
            r_rem[g+1] <= n_ge ? r_rem[g] - n_sub : r_rem[g];
            r_den[g+1] <= r_den[g];
            r_quo[g+1] <= {r_quo[g][QB-2:0], n_ge};
            r_neg[g+1] <= r_neg[g];
            r_ovf[g+1] <= r_ovf[g];
        end
    end

    logic [QB-1:0] w_q;
    assign w_q = r_quo[QB];

    always_ff @(posedge i_clk) begin
        if (r_neg[QB]) begin
            if (r_ovf[QB] || (w_q > QB'(-COMP_MIN))) begin
                o_quo  <= t_comp'(COMP_MIN);
                o_clip <= 1'b1;
            end else begin
                o_quo  <= t_comp'(COMP_W'(0) - COMP_W'(w_q));
                o_clip <= 1'b0;
            end
        end else begin
            if (r_ovf[QB] || (w_q > QB'(COMP_MAX))) begin
                o_quo  <= t_comp'(COMP_MAX);
                o_clip <= 1'b1;
            end else begin
                o_quo  <= t_comp'(w_q);
                o_clip <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[design/cxc_mat_row.sv]
// One matrix row lane: three products, rounded sum and saturation.
`default_nettype none

module cxc_mat_row
    import cxc_pkg::*;
(
    input  wire logic i_clk,
    input  wire t_vec i_vec,
    input  wire t_coef_row i_row,
    output t_comp     o_val,
    output logic      o_clip
);

    logic signed [MUL_W-1:0] r_p0, r_p1, r_p2;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [ACC_W-1:0] w_rnd;

    always_ff @(posedge i_clk) begin
        r_p0 <= MUL_W'(i_vec.a) * MUL_W'(i_row.k0);
        r_p1 <= MUL_W'(i_vec.b) * MUL_W'(i_row.k1);
        r_p2 <= MUL_W'(i_vec.c) * MUL_W'(i_row.k2);
    end

    // Round half up, then floor by the fraction width.
    assign w_acc = ACC_W'(r_p0) + ACC_W'(r_p1) + ACC_W'(r_p2) + ACC_W'(HALF);
    assign w_rnd = w_acc >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (w_rnd > ACC_W'(COMP_MAX)) begin
            o_val  <= t_comp'(COMP_MAX);
            o_clip <= 1'b1;
        end else if (w_rnd < ACC_W'(COMP_MIN)) begin
            o_val  <= t_comp'(COMP_MIN);
            o_clip <= 1'b1;
        end else begin
            o_val  <= t_comp'(w_rnd);
            o_clip <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[design/cie_xyz_color_space_converter_top.sv]
// Top level of the CIE XYZ / linear RGB / xyY colour space converter.
// The result strobe o_done rises once a transfer has passed the input, operand and divider
// stages, the matrix operand stage, the matrix lanes and the result register.
// Throughput: one transfer every cycle, o_busy is never raised, as every unit is pipelined.
// Reset: synchronous active-low i_rst_n clears the valid pipeline only; no result
// strobe appears until a fresh transfer has travelled the whole pipeline.
`default_nettype none

module cie_xyz_color_space_converter_top
    import cxc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_cmd i_cmd,
    output logic      o_busy,
    output logic      o_done,
    output t_res      o_res
);

    // The pipeline never stalls, so a new transfer is welcome on every cycle.
    assign o_busy = 1'b0;

    // Input stage: the command is captured as it is.
    logic r_v0;
    t_cmd r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= i_cmd;
    end

    // Operand stage: the divider numerators and the common divisor are
    // formed here. For xyY to RGB the luminance products need a multiplier
    // each, and they are registered before the divider lanes take them.
    logic signed [DEN_W-1:0]  n_sum;
    logic signed [OMXY_W-1:0] n_omxy;
    logic signed [PROD_W-1:0] n_num0, n_num1;
    logic signed [DEN_W-1:0]  n_den;
    logic                     n_zdiv;

    always_comb begin
        n_sum  = DEN_W'(r_cmd.comp_a) + DEN_W'(r_cmd.comp_b) + DEN_W'(r_cmd.comp_c);
        n_omxy = OMXY_W'(ONE) - OMXY_W'(r_cmd.comp_a) - OMXY_W'(r_cmd.comp_b);
        if (r_cmd.func == FN_XYY2RGB) begin
            n_num0 = PROD_W'(r_cmd.comp_c) * PROD_W'(r_cmd.comp_a);
            n_num1 = PROD_W'(r_cmd.comp_c) * PROD_W'(n_omxy);
            n_den  = DEN_W'(r_cmd.comp_b);
            n_zdiv = (r_cmd.comp_b == '0);
        end else begin
            n_num0 = PROD_W'(r_cmd.comp_a) <<< FRAC_BITS;
            n_num1 = PROD_W'(r_cmd.comp_b) <<< FRAC_BITS;
            n_den  = n_sum;
            n_zdiv = (r_cmd.func == FN_XYZ2XYY) && (n_sum == '0);
        end
    end

    logic                     r_v1;
    logic signed [PROD_W-1:0] r_num0, r_num1;
    logic signed [DEN_W-1:0]  r_den;
    t_side                    r_side1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num0  <= n_num0;
        r_num1  <= n_num1;
        r_den   <= n_den;
        r_side1 <= '{func: r_cmd.func, zdiv: n_zdiv,
                     v: '{a: r_cmd.comp_a, b: r_cmd.comp_b, c: r_cmd.comp_c}};
    end

    // Two divider lanes work side by side on the two quotients of an item.
    t_comp w_q0, w_q1;
    logic  w_c0, w_c1;

    cxc_div u_div0 (
        .i_clk  (i_clk),
        .i_num  (r_num0),
        .i_den  (r_den),
        .o_quo  (w_q0),
        .o_clip (w_c0)
    );

    cxc_div u_div1 (
        .i_clk  (i_clk),
        .i_num  (r_num1),
        .i_den  (r_den),
        .o_quo  (w_q1),
        .o_clip (w_c1)
    );

    // The item's other fields ride alongside the dividers in a delay line
    // of the same depth.
    logic  r_dv [DIV_LAT];
    t_side r_ds [DIV_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else begin
            r_dv[0] <= r_v1;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ds[0] <= r_side1;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_ds[i] <= r_ds[i-1];
        end
    end

    // Matrix operand stage: for xyY to RGB the rebuilt X and Z take the
    // place of the first and third components; the other modes pass the
    // triple straight to the matrix lanes.
    t_side w_dsl;
    assign w_dsl = r_ds[DIV_LAT-1];

    logic [2:0] r_mv;
    t_vec       r_mvec;
    t_vec       r_mxy [3];
    logic [1:0] r_mfn [3];
    logic       r_mz  [3];
    logic       r_mcl [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= '0;
        end else begin
            r_mv <= {r_mv[1:0], r_dv[DIV_LAT-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dsl.func == FN_XYY2RGB) begin
            r_mvec <= '{a: w_q0, b: w_dsl.v.c, c: w_q1};
        end else begin
            r_mvec <= w_dsl.v;
        end
        r_mxy[0] <= '{a: w_q0, b: w_q1, c: w_dsl.v.b};
        r_mfn[0] <= w_dsl.func;
        r_mz[0]  <= w_dsl.zdiv;
        r_mcl[0] <= ((w_dsl.func == FN_XYZ2XYY) || (w_dsl.func == FN_XYY2RGB))
                    && (w_c0 || w_c1);
        for (int i = 1; i < 3; i++) begin
            r_mxy[i] <= r_mxy[i-1];
            r_mfn[i] <= r_mfn[i-1];
            r_mz[i]  <= r_mz[i-1];
            r_mcl[i] <= r_mcl[i-1];
        end
    end

    // Three matrix lanes, one per output row; the coefficient set follows
    // the operation of the item entering the lanes.
    t_comp w_row  [3];
    logic  w_rclp [3];

    for (genvar r = 0; r < 3; r++) begin : g_row
        t_coef_row w_coef;
        always_comb begin
            if (r_mfn[0] == FN_RGB2XYZ) begin
                w_coef = '{k0: RGB2XYZ_K[3*r], k1: RGB2XYZ_K[3*r+1], k2: RGB2XYZ_K[3*r+2]};
            end else begin
                w_coef = '{k0: XYZ2RGB_K[3*r], k1: XYZ2RGB_K[3*r+1], k2: XYZ2RGB_K[3*r+2]};
            end
        end

        cxc_mat_row u_row (
            .i_clk  (i_clk),
            .i_vec  (r_mvec),
            .i_row  (w_coef),
            .o_val  (w_row[r]),
            .o_clip (w_rclp[r])
        );
    end

    // Merging stage: choose between the chromaticity result and the matrix
    // lanes, and force zeros where the divisor was zero.
    t_res n_res;

    always_comb begin
        if (r_mz[2]) begin
            n_res = '{out_a: '0, out_b: '0, out_c: '0, zero_divisor: 1'b1, clipped: 1'b0};
        end else if (r_mfn[2] == FN_XYZ2XYY) begin
            n_res = '{out_a: r_mxy[2].a, out_b: r_mxy[2].b, out_c: r_mxy[2].c,
                      zero_divisor: 1'b0, clipped: r_mcl[2]};
        end else begin
            n_res = '{out_a: w_row[0], out_b: w_row[1], out_c: w_row[2],
                      zero_divisor: 1'b0,
                      clipped: r_mcl[2] || w_rclp[0] || w_rclp[1] || w_rclp[2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_mv[2];
        end
    end

    always_ff @(posedge i_clk) begin
        o_res <= n_res;
    end

endmodule

`default_nettype wire
